// File: hdl/erc_pkg.sv
// Package for the encoder revolution counter: field widths, milestone offsets,
// configuration register indexes and turn event codes.
// No dependencies.
package erc_pkg;

    localparam int ANGLE_W         = 13;
    localparam int WINDOW_W        = 12;
    localparam int COUNT_W         = 16;
    localparam int COUNTS_PER_TURN = 1 << ANGLE_W;

    localparam int NUM_MILESTONES  = 3;
    localparam int STACK_DEPTH     = 4;
    localparam int MS_W            = 2;
    localparam int TOP_W           = 2;

    // milestones sit at k * COUNTS_PER_TURN / 3
    localparam logic [ANGLE_W-1:0] MILESTONE_OFS [NUM_MILESTONES] = '{
        ANGLE_W'(0),
        ANGLE_W'(COUNTS_PER_TURN / 3),
        ANGLE_W'((2 * COUNTS_PER_TURN) / 3)
    };

    localparam logic [ANGLE_W-1:0]  START_ANGLE_RESET = '0;
    localparam logic [WINDOW_W-1:0] NEAR_WINDOW_RESET = WINDOW_W'(2000);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ANGLE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ANGLE = 1'b0,
        REG_NEAR_WINDOW = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_FWD  = 2'd1,
        TURN_BWD  = 2'd2
    } turn_event_t;

    localparam logic [MS_W-1:0] MS_FORWARD = MS_W'(1);

endpackage

// File: hdl/erc_ifs.sv
// Valid/ready channel interfaces of the encoder revolution counter:
// angle samples in, revolution results out, configuration writes.
// Depends on erc_pkg.
interface erc_sample_if
    import erc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;
    logic               clear_count;

    modport source (output valid, output angle, output clear_count, input ready);
    modport sink   (input valid, input angle, input clear_count, output ready);
endinterface

interface erc_result_if
    import erc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] revolutions;
    logic [1:0]                turn_event;

    modport source (output valid, output revolutions, output turn_event, input ready);
    modport sink   (input valid, input revolutions, input turn_event, output ready);
endinterface

interface erc_cfg_if
    import erc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/encoder_revolution_counter.sv
// Top level of the encoder revolution counter: milestone detection, milestone
// stack and the wrapping revolution count.
// Depends on erc_pkg and the channel interfaces in erc_ifs.sv.

// One result per angle sample, one sample per clock sustained while the result
// side does not stall. As a sample is taken into the input register its angle
// relative to start_angle is compared against the three milestone windows; it
// is then folded into the milestone stack and revolution count as it moves into
// the output register, so a result is valid once its sample has moved through
// the input register into the output register. The output register lets a new
// sample be taken while a result waits; when the result side stalls the
// pipeline holds and sample.ready drops once both registers are full.
// revolutions reports the count after this sample's update and before
// clear_count takes effect. Configuration writes are always accepted and
// should only be done while no sample is in flight.
module encoder_revolution_counter
    import erc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    erc_sample_if.sink    sample,
    erc_result_if.source  result,
    erc_cfg_if.sink       cfg
);

    logic [ANGLE_W-1:0]  start_angle_reg;
    logic [WINDOW_W-1:0] near_window_reg;

    logic                      s1_valid_reg;
    logic [NUM_MILESTONES-1:0] s1_near_reg;
    logic                      s1_clear_reg;

    logic [MS_W-1:0]    stack_reg [STACK_DEPTH];
    logic [TOP_W-1:0]   top_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] revolutions_reg;
    turn_event_t        turn_event_reg;

    logic                      out_load;
    logic                      step;
    logic [ANGLE_W-1:0]        rel_angle;
    logic [NUM_MILESTONES-1:0] near_next;

    logic [MS_W-1:0]    stack_next [STACK_DEPTH];
    logic [TOP_W-1:0]   top_next;
    logic [COUNT_W-1:0] count_next;
    turn_event_t        turn_event_next;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= START_ANGLE_RESET;
            near_window_reg <= NEAR_WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_START_ANGLE: start_angle_reg <= cfg.data[ANGLE_W-1:0];
                REG_NEAR_WINDOW: near_window_reg <= cfg.data[WINDOW_W-1:0];
                default:         start_angle_reg <= start_angle_reg;
            endcase
        end
    end

    // handshake
    assign out_load     = !out_valid_reg || result.ready;
    assign step         = s1_valid_reg && out_load;
    assign sample.ready = !s1_valid_reg || out_load;

    // input stage: window compares
    assign rel_angle = sample.angle - start_angle_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_MILESTONES; k++)
        begin
            near_next[k] = (rel_angle - MILESTONE_OFS[k]) < {1'b0, near_window_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            s1_near_reg  <= near_next;
            s1_clear_reg <= sample.clear_count;
        end
    end

    // milestone stack and count update
    always_comb
    begin
        stack_next      = stack_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        turn_event_next = TURN_NONE;

        // milestones in order, each may push; a push onto a full stack is dropped
        for (int k = 0; k < NUM_MILESTONES; k++)
        begin
            if (s1_near_reg[k] && (MS_W'(k) != stack_next[top_next])
                && (top_next != TOP_W'(STACK_DEPTH - 1)))
            begin
                top_next             = top_next + 1'b1;
                stack_next[top_next] = MS_W'(k);
            end
        end

        // back-and-forth motion undoes two entries
        if ((top_next >= TOP_W'(2))
            && (stack_next[top_next] == stack_next[top_next - TOP_W'(2)]))
        begin
            top_next = top_next - TOP_W'(2);
        end

        // full turn: direction from the second entry
        if ((top_next == TOP_W'(STACK_DEPTH - 1)) && (stack_next[STACK_DEPTH - 1] == stack_next[0]))
        begin
            if (stack_next[1] == MS_FORWARD)
            begin
                count_next      = count_reg + 1'b1;
                turn_event_next = TURN_FWD;
            end
            else
            begin
                count_next      = count_reg - 1'b1;
                turn_event_next = TURN_BWD;
            end
            top_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stack_reg[i] <= '0;
            end
            top_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                stack_reg <= stack_next;
                top_reg   <= top_next;
                count_reg <= s1_clear_reg ? '0 : count_next;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            revolutions_reg <= count_next;
            turn_event_reg  <= turn_event_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.revolutions = $signed(revolutions_reg);
    assign result.turn_event  = turn_event_reg;

    // checks
    a_fwd_increments: assert property (@(posedge clk) disable iff (!rst_n)
        (step && turn_event_next == TURN_FWD)
        |=> (out_valid_reg && revolutions_reg == $past(count_reg) + 16'd1))
        else $error("forward turn did not add one revolution");

    a_no_turn_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step && turn_event_next == TURN_NONE)
        |=> (revolutions_reg == $past(count_reg)))
        else $error("count changed without a turn");

    a_turn_empties_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (step && turn_event_next != TURN_NONE) |=> (top_reg == '0))
        else $error("stack not emptied after a turn");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (out_valid_reg && !result.ready && s1_valid_reg))
        else $error("sample side stalled while pipeline could advance");

endmodule

// File: bench/encoder_revolution_counter_test.sv
`timescale 1ns / 100ps
// Self-checking bench for encoder_revolution_counter: milestone walks, window extremes,
// back-pressure and count wrap, checked against an in-bench milestone stack model.
// Depends on erc_pkg, the channel interfaces in erc_ifs.sv and the counter RTL.
module encoder_revolution_counter_test;
    import erc_pkg::*;

    localparam int TURN_COUNTS  = 8192;
    localparam int HOLD_CYCLES  = 64;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int SEG_ITEMS    = 140;

    typedef struct {
        logic signed [COUNT_W-1:0] revolutions;
        turn_event_t               ev;
    } revolution_result_t;

    logic clk;
    logic rst_n;

    erc_sample_if sample_ch();
    erc_result_if result_ch();
    erc_cfg_if    cfg_ch();

    encoder_revolution_counter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // model state and configuration
    logic [ANGLE_W-1:0]  model_start;
    logic [WINDOW_W-1:0] model_window;
    logic [MS_W-1:0]     ms_stack [STACK_DEPTH];
    logic [TOP_W-1:0]    ms_top;
    logic [COUNT_W-1:0]  turn_count;

    revolution_result_t pending_counts [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int samples_sent    = 0;
    int fwd_turns       = 0;
    int bwd_turns       = 0;
    int cfg_writes      = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_seq        = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int stall_cycles    = 0;

    always #2 clk = ~clk;

    function automatic logic [ANGLE_W-1:0] milestone_offset(input int k);
        return ANGLE_W'((k * TURN_COUNTS) / 3);
    endfunction

    task automatic advance_counter_model(input logic [ANGLE_W-1:0] ang, input logic clr);
        logic [ANGLE_W-1:0] rel;
        logic [ANGLE_W-1:0] ahead;
        revolution_result_t exp_r;
        exp_r.ev = TURN_NONE;
        rel = ang - model_start;
        for (int k = 0; k < NUM_MILESTONES; k++)
        begin
            ahead = rel - milestone_offset(k);
            if (ahead < {1'b0, model_window} && MS_W'(k) != ms_stack[ms_top]
                && ms_top != TOP_W'(STACK_DEPTH - 1))
            begin
                ms_top = ms_top + 1'b1;
                ms_stack[ms_top] = MS_W'(k);
            end
        end
        // back-and-forth undoes the last two milestones
        if (ms_top >= 2 && ms_stack[ms_top] == ms_stack[ms_top - 2'd2])
            ms_top = ms_top - 2'd2;
        // full cycle: direction follows the first milestone reached
        if (ms_top == 2'd3 && ms_stack[3] == ms_stack[0])
        begin
            if (ms_stack[1] == MS_FORWARD)
            begin
                turn_count = turn_count + 1'b1;
                exp_r.ev = TURN_FWD;
                fwd_turns++;
            end
            else
            begin
                turn_count = turn_count - 1'b1;
                exp_r.ev = TURN_BWD;
                bwd_turns++;
            end
            ms_top = '0;
        end
        exp_r.revolutions = turn_count;
        pending_counts.push_back(exp_r);
        if (clr)
            turn_count = '0;
    endtask

    task automatic send_sample(input logic [ANGLE_W-1:0] ang, input logic clr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.angle       <= ang;
        sample_ch.clear_count <= clr;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        samples_sent++;
        advance_counter_model(ang, clr);
    endtask

    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_writes++;
        if (idx == REG_START_ANGLE)
            model_start = value;
        else
            model_window = value[WINDOW_W-1:0];
    endtask

    task automatic configure(input logic [ANGLE_W-1:0] start, input logic [WINDOW_W-1:0] window);
        wait_for_results();
        write_reg(REG_START_ANGLE, start);
        write_reg(REG_NEAR_WINDOW, CFG_DATA_W'(window));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_turn(input int first_ms, input int second_ms);
        send_sample(model_start + milestone_offset(first_ms) + 13'd10, 1'b0);
        send_sample(model_start + milestone_offset(second_ms) + 13'd10, 1'b0);
        send_sample(model_start + 13'd10, 1'b0);
    endtask

    // reset values of both registers, turns both ways, undo and clear
    task automatic test_directed_turns();
        send_sample(13'd0, 1'b0);
        send_sample(13'd4000, 1'b0);
        send_turn(1, 2);
        send_turn(2, 1);
        // second backward turn takes the count below zero
        send_turn(2, 1);
        send_sample(13'd2740, 1'b0);
        send_sample(13'd5470, 1'b0);
        send_sample(13'd2740, 1'b0);
        send_sample(13'd5470, 1'b0);
        send_sample(13'd10, 1'b0);
        send_sample(13'd8191, 1'b1);
    endtask

    task automatic test_window_extremes();
        // zero window never matches
        configure(13'd8191, 12'd0);
        send_sample(13'd8191, 1'b0);
        send_sample(13'd2729, 1'b0);
        send_sample(13'd5460, 1'b0);
        // one-count window, hit exactly on each milestone
        configure(13'd8191, 12'd1);
        send_sample(13'd2729, 1'b0);
        send_sample(13'd5460, 1'b0);
        send_sample(13'd8191, 1'b0);
        // overlapping windows, second push of a step lands on a full stack
        configure(13'd0, 12'd4095);
        send_sample(13'd2740, 1'b0);
        send_sample(13'd5470, 1'b0);
        send_sample(13'd3000, 1'b0);
    endtask

    task automatic test_random_walks();
        int walk_ms;
        int pick;
        int span;
        logic [ANGLE_W-1:0]  start;
        logic [WINDOW_W-1:0] window;
        logic [ANGLE_W-1:0]  ang;
        walk_ms = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct <= (phase == 0) ? 32 : (phase == 1) ? 69 : 0;
            recv_idle_pct <= (phase == 0) ? 69 : (phase == 1) ? 32 : 0;
            for (int seg = 0; seg < 3; seg++)
            begin
                pick = $urandom_range(0, 3);
                start = (pick == 0) ? 13'd0 : (pick == 1) ? 13'd8191 : 13'($urandom_range(0, 8191));
                pick = $urandom_range(0, 5);
                window = (pick == 0) ? 12'd1 : (pick == 1) ? 12'd2730 :
                         (pick == 2) ? 12'($urandom_range(2731, 4095)) :
                         12'($urandom_range(1, 2730));
                configure(start, window);
                if ((phase == 2 && seg == 1) || (phase == 0 && seg == 2))
                    hold_seq <= hold_seq + 1;
                for (int i = 0; i < SEG_ITEMS; i++)
                begin
                    if (phase == 1 && seg == 0 && i == SEG_ITEMS / 2)
                        wait_for_results();
                    pick = $urandom_range(0, 99);
                    span = (model_window == 0) ? 1 : int'(model_window);
                    if (pick < 85)
                    begin
                        if (pick < 45)
                            walk_ms = (walk_ms + 1) % NUM_MILESTONES;
                        else if (pick < 80)
                            walk_ms = (walk_ms + 2) % NUM_MILESTONES;
                        ang = model_start + milestone_offset(walk_ms)
                              + ANGLE_W'($urandom_range(0, span - 1));
                    end
                    else
                        ang = ANGLE_W'($urandom_range(0, TURN_COUNTS - 1));
                    send_sample(ang, $urandom_range(0, 99) < 4);
                end
            end
        end
    endtask

    // backward turns take the count below zero, forward turns bring it back across
    task automatic test_count_wrap();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        configure(13'd0, 12'd2000);
        send_sample(13'd4000, 1'b1);
        repeat (6) send_turn(2, 1);
        repeat (10) send_turn(1, 2);
        send_sample(13'd4000, 1'b1);
    endtask

    task automatic check_result();
        revolution_result_t want;
        if (pending_counts.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result: revolutions %0d turn_event %0d",
                         result_ch.revolutions, result_ch.turn_event);
        end
        else
        begin
            want = pending_counts.pop_front();
            if (result_ch.revolutions !== want.revolutions
                || result_ch.turn_event !== want.ev)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result %0d: revolutions exp %0d got %0d, turn_event exp %0d got %0d",
                             results_checked, want.revolutions, result_ch.revolutions,
                             want.ev, result_ch.turn_event);
            end
        end
        results_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seq != hold_served)
        begin
            hold_served = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         stall_cycles, pending_counts.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.angle       = '0;
        sample_ch.clear_count = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_START_ANGLE;
        cfg_ch.data           = '0;
        model_start           = '0;
        model_window          = 12'd2000;
        ms_stack              = '{default: '0};
        ms_top                = '0;
        turn_count            = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_turns();
        test_window_extremes();
        test_random_walks();
        test_count_wrap();

        wait_for_results();
        repeat (8) @(posedge clk);
        $display("covered %0d samples, %0d forward and %0d backward turns, %0d register writes",
                 samples_sent, fwd_turns, bwd_turns, cfg_writes);
        $display("incl. zero and overlapping windows, full stack, stalls and count crossing zero");
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
